### rtl/mfmd_pkg.sv
// shared types, constants and functions for the mfm track deframer
`timescale 1ns / 1ps
`default_nettype none
package mfmd_pkg;

  localparam int MAX_WORDS = 4096;
  localparam int LEN_LIMIT = (MAX_WORDS < 4096) ? MAX_WORDS : 4096;
  localparam int LEN_W     = 13;
  localparam int IDX_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [31:0]      SYNC_RESET = 32'h8944_8944;
  localparam logic [31:0]      KEY_RESET  = 32'h2294_5567;
  localparam logic [LEN_W-1:0] LEN_RESET  = 13'd3136;
  localparam logic [LEN_W-1:0] LEN_MIN    = 13'd4;
  localparam logic [LEN_W-1:0] LEN_CAP    = LEN_W'(LEN_LIMIT);
  localparam logic [15:0]      DATA_MASK  = 16'h5555;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_PATTERN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHECKSUM_KEY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WORDS_IN_BLOCK = 2'd2;

  // one completed 32-bit raw group with its classification
  typedef struct packed {
    logic [31:0]      raw;
    logic [IDX_W-1:0] idx;
    logic             last;
    logic             add;
  } group_t;

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] w);
    logic [LEN_W-1:0] n;
    n = (w > LEN_CAP) ? LEN_CAP : w;
    n[0] = 1'b0;
    if (n < LEN_MIN) n = LEN_MIN;
    return n;
  endfunction

  // mfm even/odd: clock bits dropped, first half carries the odd data bits
  function automatic logic [15:0] mfm_decode(input logic [31:0] raw);
    return ((raw[31:16] & DATA_MASK) << 1) | (raw[15:0] & DATA_MASK);
  endfunction

endpackage
`default_nettype wire

### rtl/mfmd_queue.sv
// short queue of raw groups between the front and back parts
`timescale 1ns / 1ps
`default_nettype none
module mfmd_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire mfmd_pkg::group_t wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output mfmd_pkg::group_t      rd_data,
  output logic                  rd_valid
);

  localparam int PTR_W = (mfmd_pkg::QUEUE_DEPTH > 1) ? $clog2(mfmd_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(mfmd_pkg::QUEUE_DEPTH + 1);

  mfmd_pkg::group_t slots [mfmd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(mfmd_pkg::QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(mfmd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(mfmd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/mfmd_front.sv
// front part: sync hunt, raw group assembly and word classification
`timescale 1ns / 1ps
`default_nettype none
module mfmd_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          bit_valid,
  input  wire logic                          bit_in,
  input  wire logic [31:0]                   sync_pattern,
  input  wire logic [mfmd_pkg::LEN_W-1:0]    words_in_block,
  output logic                               grp_valid,
  output mfmd_pkg::group_t                   grp
);

  logic [31:0]                  sync_window;
  logic [31:0]                  raw_group;
  logic                         in_block;
  logic [4:0]                   bit_position;
  logic [mfmd_pkg::IDX_W-1:0]   word_counter;
  logic [31:0]                  window_next;
  logic [31:0]                  group_next;
  logic [mfmd_pkg::LEN_W-1:0]   n;
  logic                         last;
  logic                         add;

  assign window_next = {sync_window[30:0], bit_in};
  assign group_next  = {raw_group[30:0], bit_in};
  assign n           = mfmd_pkg::eff_len(words_in_block);
  assign last        = ({1'b0, word_counter} >= (n - 1'b1));
  assign add         = word_counter[0] && ({1'b0, word_counter} < (n - 2'd2));

  assign grp_valid = bit_valid && in_block && (bit_position == 5'd31);
  assign grp.raw   = group_next;
  assign grp.idx   = word_counter;
  assign grp.last  = last;
  assign grp.add   = add;

  always_ff @(posedge clk) begin
    if (bit_valid && in_block) begin
      raw_group <= group_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_window  <= '0;
      in_block     <= 1'b0;
      bit_position <= '0;
      word_counter <= '0;
    end else if (bit_valid) begin
      sync_window <= window_next;
      if (!in_block) begin
        if (window_next == sync_pattern) begin
          in_block     <= 1'b1;
          bit_position <= '0;
          word_counter <= '0;
        end
      end else begin
        bit_position <= bit_position + 1'b1;
        if (bit_position == 5'd31) begin
          if (last) begin
            in_block     <= 1'b0;
            word_counter <= '0;
          end else begin
            word_counter <= word_counter + 1'b1;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

### rtl/mfmd_back.sv
// back part: mfm decode, checksum accumulation and result register
`timescale 1ns / 1ps
`default_nettype none
module mfmd_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        grp_valid,
  input  wire mfmd_pkg::group_t            grp,
  output logic                             grp_take,
  input  wire logic [31:0]                 checksum_key,
  output logic                             out_valid,
  input  wire logic                        out_take,
  output logic [15:0]                      data_word,
  output logic [mfmd_pkg::IDX_W-1:0]       word_index,
  output logic                             last_word,
  output logic                             checksum_ok
);

  logic [31:0] running_sum;
  logic [15:0] upper_half;
  logic [15:0] word;
  logic [31:0] pair;

  assign word     = mfmd_pkg::mfm_decode(grp.raw);
  assign pair     = {upper_half, word};
  assign grp_take = grp_valid && (!out_valid || out_take);

  always_ff @(posedge clk) begin
    if (grp_take) begin
      data_word   <= word;
      word_index  <= grp.idx;
      last_word   <= grp.last;
      checksum_ok <= grp.last && (pair == running_sum);
      if (!grp.last) begin
        if (!grp.idx[0]) begin
          upper_half <= word;
          // first word of a block restarts the sum
          if (grp.idx == '0) begin
            running_sum <= '0;
          end
        end else if (grp.add) begin
          running_sum <= running_sum + (checksum_key ^ pair);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (grp_take) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

### rtl/mfm_track_deframer_checksum.sv
// top level of the mfm track deframer with additive block checksum
//
// raw flux bits enter one per transaction on raw_bit (push / full). the
// block hunts for sync_pattern in a 32-bit window; after a match every 32
// bits are mfm even/odd decoded into a 16-bit word that leaves on the
// result side (empty / pop) with its index. the last word of a block
// carries last_word and checksum_ok, then hunting resumes.
// input rate is one bit per cycle while full is low; each group passes the
// queue and then the result register, at most one result per 32 input bits.
// the front part and the back part are parted by a two-entry group queue,
// so full only rises when that queue and the result register are both
// held by a stalled receiver; a stalled receiver keeps the result stable.
// configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) is always
// ready and should only be written while the block is idle.
// synchronous reset clears the window, the block state and all queues and
// restores the registers to their default values.
`timescale 1ns / 1ps
`default_nettype none
module mfm_track_deframer_checksum (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               push,
  output logic                                    full,
  input  wire logic                               raw_bit,
  output logic                                    empty,
  input  wire logic                               pop,
  output logic [15:0]                             data_word,
  output logic [mfmd_pkg::IDX_W-1:0]              word_index,
  output logic                                    last_word,
  output logic                                    checksum_ok,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [mfmd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [31:0]                        cfg_data
);

  logic [31:0]                 sync_pattern;
  logic [31:0]                 checksum_key;
  logic [mfmd_pkg::LEN_W-1:0]  words_in_block;
  logic                        bit_valid;
  logic                        f_valid;
  mfmd_pkg::group_t            f_grp;
  logic                        q_full;
  logic                        q_valid;
  mfmd_pkg::group_t            q_grp;
  logic                        q_take;
  logic                        out_valid;
  logic                        out_take;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign bit_valid = push && !q_full;
  assign empty     = !out_valid;
  assign out_take  = pop && out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_pattern   <= mfmd_pkg::SYNC_RESET;
      checksum_key   <= mfmd_pkg::KEY_RESET;
      words_in_block <= mfmd_pkg::LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mfmd_pkg::REG_SYNC_PATTERN:   sync_pattern   <= cfg_data;
        mfmd_pkg::REG_CHECKSUM_KEY:   checksum_key   <= cfg_data;
        mfmd_pkg::REG_WORDS_IN_BLOCK: words_in_block <= cfg_data[mfmd_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  mfmd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .bit_valid      (bit_valid),
    .bit_in         (raw_bit),
    .sync_pattern   (sync_pattern),
    .words_in_block (words_in_block),
    .grp_valid      (f_valid),
    .grp            (f_grp)
  );

  mfmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (f_valid),
    .wr_data  (f_grp),
    .full     (q_full),
    .rd_en    (q_take),
    .rd_data  (q_grp),
    .rd_valid (q_valid)
  );

  mfmd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .grp_valid    (q_valid),
    .grp          (q_grp),
    .grp_take     (q_take),
    .checksum_key (checksum_key),
    .out_valid    (out_valid),
    .out_take     (out_take),
    .data_word    (data_word),
    .word_index   (word_index),
    .last_word    (last_word),
    .checksum_ok  (checksum_ok)
  );

endmodule
`default_nettype wire

### rtl/mfmd_checker.sv
// port-level checks for the mfm track deframer
`timescale 1ns / 1ps
`default_nettype none
module mfmd_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          empty,
  input wire logic                          pop,
  input wire logic [15:0]                   data_word,
  input wire logic [mfmd_pkg::IDX_W-1:0]    word_index,
  input wire logic                          last_word,
  input wire logic                          checksum_ok
);

  // nothing waits on the result side right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending after reset");

  // a match is only reported on the final word of a block
  a_ok_on_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && checksum_ok) |-> last_word)
    else $error("checksum_ok outside last word");

  // a block holds at least two data words and two checksum words
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (!empty && last_word) |-> (word_index >= 12'd3))
    else $error("block ended too early");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(data_word) && $stable(word_index)
                          && $stable(last_word) && $stable(checksum_ok)))
    else $error("stalled result changed");

endmodule

bind mfm_track_deframer_checksum mfmd_checker u_mfmd_checker (
  .clk         (clk),
  .rst         (rst),
  .empty       (empty),
  .pop         (pop),
  .data_word   (data_word),
  .word_index  (word_index),
  .last_word   (last_word),
  .checksum_ok (checksum_ok)
);
`default_nettype wire

### tb/mfm_track_deframer_checksum_tb.sv
// self-checking testbench for the mfm track deframer with block checksum
`timescale 1ns / 1ps
module mfm_track_deframer_checksum_tb;

  localparam int RESET_CYCLES   = 11;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  // raw bits fed before the closing stretch starts
  localparam int BIT_BUDGET     = 700;
  localparam int MAX_REPORTS    = 10;
  // index with no register behind it, writes to it change nothing
  localparam logic [mfmd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum int {BLK_GOOD, BLK_CORRUPT, BLK_SYNC_TAIL} block_kind_t;

  typedef struct packed {
    logic [15:0]                data;
    logic [mfmd_pkg::IDX_W-1:0] index;
    logic                       last;
    logic                       ok;
  } word_t;

  class deframer_scoreboard;
    logic [31:0]                sync_pat;
    logic [31:0]                key;
    logic [mfmd_pkg::LEN_W-1:0] len_reg;
    logic [31:0]                window;
    logic                       in_block;
    logic [4:0]                 bit_pos;
    logic [31:0]                group;
    logic [mfmd_pkg::IDX_W-1:0] word_cnt;
    logic [31:0]                sum;
    logic [15:0]                upper;
    word_t                      pending[$];
    int errors, words_checked, blocks_closed, blocks_ok, busy_bits, bits_total;

    function new();
      sync_pat = mfmd_pkg::SYNC_RESET;
      key      = mfmd_pkg::KEY_RESET;
      len_reg  = mfmd_pkg::LEN_RESET;
      window   = '0;
      in_block = 1'b0;
      bit_pos  = '0;
      group    = '0;
      word_cnt = '0;
      sum      = '0;
      upper    = '0;
      errors = 0;
      words_checked = 0;
      blocks_closed = 0;
      blocks_ok = 0;
      busy_bits = 0;
      bits_total = 0;
    endfunction

    function int block_len();
      int n;
      n = int'(len_reg);
      if (n > mfmd_pkg::LEN_LIMIT) n = mfmd_pkg::LEN_LIMIT;
      n = n - (n % 2);
      if (n < 4) n = 4;
      return n;
    endfunction

    function void write_reg(logic [mfmd_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        mfmd_pkg::REG_SYNC_PATTERN:   sync_pat = val;
        mfmd_pkg::REG_CHECKSUM_KEY:   key = val;
        mfmd_pkg::REG_WORDS_IN_BLOCK: len_reg = val[mfmd_pkg::LEN_W-1:0];
        default: ;
      endcase
    endfunction

    // even raw bits carry data; upper half holds the odd data bits
    function logic [15:0] decode_group(logic [31:0] raw);
      logic [15:0] w;
      for (int k = 0; k < 8; k++) begin
        w[2*k+1] = raw[16+2*k];
        w[2*k]   = raw[2*k];
      end
      return w;
    endfunction

    function void note_bit(logic b);
      word_t exp_word;
      int n;
      logic [31:0] pair;
      bits_total++;
      window = {window[30:0], b};
      if (!in_block) begin
        if (window == sync_pat) begin
          in_block = 1'b1;
          bit_pos  = '0;
          group    = '0;
          word_cnt = '0;
          sum      = '0;
          upper    = '0;
          busy_bits++;
        end
        return;
      end
      busy_bits++;
      group = {group[30:0], b};
      if (bit_pos != 5'd31) begin
        bit_pos++;
        return;
      end
      bit_pos = '0;
      n = block_len();
      exp_word.data  = decode_group(group);
      exp_word.index = word_cnt;
      exp_word.last  = (int'(word_cnt) >= n - 1);
      exp_word.ok    = 1'b0;
      pair = {upper, exp_word.data};
      if (exp_word.last) begin
        exp_word.ok = (pair == sum);
        in_block = 1'b0;
        word_cnt = '0;
        blocks_closed++;
        if (exp_word.ok) blocks_ok++;
      end else begin
        if (!word_cnt[0]) begin
          upper = exp_word.data;
        end else if (int'(word_cnt) < n - 2) begin
          sum = sum + (key ^ pair);
        end
        word_cnt = word_cnt + 1'b1;
      end
      pending.push_back(exp_word);
    endfunction

    function void report(string what, word_t want, word_t got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%s: expected data %h index %0d last %b ok %b,", what,
                 want.data, want.index, want.last, want.ok,
                 " got data %h index %0d last %b ok %b",
                 got.data, got.index, got.last, got.ok);
    endfunction

    function void check_word(logic [15:0] d, logic [mfmd_pkg::IDX_W-1:0] i,
                             logic l, logic o);
      word_t got;
      word_t want;
      got = {d, i, l, o};
      if (pending.size() == 0) begin
        report("word with none expected", '0, got);
        return;
      end
      want = pending.pop_front();
      words_checked++;
      if (got.data !== want.data || got.index !== want.index ||
          got.last !== want.last || got.ok !== want.ok)
        report("word mismatch", want, got);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic push;
  logic full;
  logic raw_bit;
  logic empty;
  logic pop;
  logic [15:0] data_word;
  logic [mfmd_pkg::IDX_W-1:0] word_index;
  logic last_word;
  logic checksum_ok;
  logic cfg_valid;
  logic cfg_ready;
  logic [mfmd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  bit idle_en = 1'b1;
  bit hold_req = 1'b0;
  int quiet_cycles = 0;
  deframer_scoreboard sb;

  mfm_track_deframer_checksum u_dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .raw_bit     (raw_bit),
    .empty       (empty),
    .pop         (pop),
    .data_word   (data_word),
    .word_index  (word_index),
    .last_word   (last_word),
    .checksum_ok (checksum_ok),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  // sample every transaction at the rising edge; results are checked before
  // the bit of the same edge is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) sb.check_word(data_word, word_index, last_word, checksum_ok);
      if (push && !full) sb.note_bit(raw_bit);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if ((pop && !empty) || (push && !full) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", quiet_cycles);
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles++;
      end
    end
  end

  // receiver: random stalls, one long hold on request
  initial begin
    pop = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end else begin
        pop <= 1'b1;
        @(negedge clk);
      end
    end
  end

  task automatic send_bit(input logic b);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    push <= 1'b1;
    raw_bit <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_group(input logic [31:0] g);
    for (int i = 31; i >= 0; i--) send_bit(g[i]);
  endtask

  task automatic send_noise(input int count);
    repeat (count) send_bit(1'($urandom_range(0, 1)));
  endtask

  // clock bits are random, the block only looks at the data bits
  function automatic logic [31:0] encode_word(input logic [15:0] w);
    logic [31:0] raw;
    raw = $urandom;
    for (int k = 0; k < 8; k++) begin
      raw[16+2*k] = w[2*k+1];
      raw[2*k]    = w[2*k];
    end
    return raw;
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_block(input bit with_sync, input block_kind_t kind);
    int n;
    int flip;
    logic [15:0] words[$];
    logic [31:0] total;
    n = sb.block_len();
    total = '0;
    for (int i = 0; i < n - 2; i++) begin
      words.push_back(pick_word());
      if (i % 2 == 1) total = total + (sb.key ^ {words[i-1], words[i]});
    end
    words.push_back(total[31:16]);
    words.push_back(total[15:0]);
    if (kind == BLK_CORRUPT) begin
      flip = $urandom_range(0, n - 1);
      words[flip] = words[flip] ^ (16'd1 << $urandom_range(0, 15));
    end
    if (with_sync) send_group(sb.sync_pat);
    for (int i = 0; i < n; i++) begin
      if (kind == BLK_SYNC_TAIL && i == n - 1) send_group(sb.sync_pat);
      else send_group(encode_word(words[i]));
    end
  endtask

  // stop offering bits until every expected word is back, then let the
  // pipeline empty out before anything else happens
  task automatic wait_drain();
    push <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [mfmd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_config();
    logic [31:0] len_val;
    case ($urandom_range(0, 3))
      0:       len_val = $urandom_range(0, 3);
      default: len_val = $urandom_range(4, 6);
    endcase
    // bits above the register width must be dropped
    len_val[31:mfmd_pkg::LEN_W] = $urandom;
    cfg_write(mfmd_pkg::REG_WORDS_IN_BLOCK, len_val);
    cfg_write(mfmd_pkg::REG_CHECKSUM_KEY,
              ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom);
    cfg_write(mfmd_pkg::REG_SYNC_PATTERN,
              ($urandom_range(0, 3) == 0) ? mfmd_pkg::SYNC_RESET : $urandom);
    if ($urandom_range(0, 7) == 0) cfg_write(REG_UNUSED, $urandom);
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    push = 1'b0;
    raw_bit = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = mfmd_pkg::REG_SYNC_PATTERN;
    cfg_data = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // default sync and key, length clamped to the top, then dropped mid-block
    cfg_write(mfmd_pkg::REG_WORDS_IN_BLOCK, 32'hFFFF_FFFF);
    send_noise(8);
    send_group(sb.sync_pat);
    repeat (4) send_group(encode_word(pick_word()));
    wait_drain();
    cfg_write(mfmd_pkg::REG_WORDS_IN_BLOCK, 32'hFFFF_E004);
    send_group(encode_word(pick_word()));
    wait_drain();

    // all-ones sync, zero key, length below minimum
    cfg_write(mfmd_pkg::REG_SYNC_PATTERN, 32'hFFFF_FFFF);
    cfg_write(mfmd_pkg::REG_CHECKSUM_KEY, 32'h0000_0000);
    cfg_write(mfmd_pkg::REG_WORDS_IN_BLOCK, 32'd0);
    // block ends on a group equal to sync: the window only matches one bit later
    send_block(1'b1, BLK_SYNC_TAIL);
    send_bit(1'b1);
    send_block(1'b0, BLK_GOOD);
    wait_drain();

    // all-zero sync, all-ones key, odd length; the receiver holds off so the
    // input backs up
    cfg_write(mfmd_pkg::REG_SYNC_PATTERN, 32'h0000_0000);
    cfg_write(mfmd_pkg::REG_CHECKSUM_KEY, 32'hFFFF_FFFF);
    cfg_write(mfmd_pkg::REG_WORDS_IN_BLOCK, 32'd5);
    cfg_write(REG_UNUSED, $urandom);
    hold_req = 1'b1;
    send_block(1'b1, BLK_CORRUPT);
    wait_drain();

    // random part
    random_config();
    while (sb.bits_total < BIT_BUDGET) begin
      case ($urandom_range(0, 9))
        0: begin
          wait_drain();
          random_config();
        end
        1: send_noise($urandom_range(1, 48));
        2: begin
          // sync with a truncated body, so the next sync lands inside the block
          send_group(sb.sync_pat);
          send_noise($urandom_range(1, 100));
        end
        3: send_block(1'b1, BLK_CORRUPT);
        default: send_block(1'b1, BLK_GOOD);
      endcase
    end

    // closing stretch at full rate on both sides
    idle_en = 1'b0;
    send_block(1'b1, BLK_GOOD);
    wait_drain();

    $display("fed %0d raw bits (%0d inside blocks), checked %0d words",
             sb.bits_total, sb.busy_bits, sb.words_checked);
    $display("closed %0d blocks, %0d with a matching checksum, %0d mismatches",
             sb.blocks_closed, sb.blocks_ok, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
